// ----- sv/quad4_strain_displacement_unit_macros.svh -----
// Assertion macros for the quad4 strain-displacement RTL back end.
`ifndef QUAD4_STRAIN_DISPLACEMENT_UNIT_MACROS_SVH
`define QUAD4_STRAIN_DISPLACEMENT_UNIT_MACROS_SVH

`ifndef SYNTH
`define QSD_ASSERT(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("qsd check failed");
`define QSD_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("qsd check failed");
`else
`define QSD_ASSERT(lbl, cond)
`define QSD_IMPLY(lbl, ante, cons)
`endif

`endif

// ----- sv/qsd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package qsd_pkg;

  localparam int FRAC_BITS = 16;
  localparam longint unsigned G_Q32 = 64'd2479700525;
  localparam longint unsigned G_VAL =
    (G_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

  localparam int COEF_W = FRAC_BITS + 2;
  localparam int PROD_W = 32 + COEF_W;
  localparam int SUMJ_W = PROD_W + 2;
  localparam int DET_W = 65;
  localparam int NUM_W = PROD_W + 1;
  localparam int DIV_SHIFT = FRAC_BITS - 2;
  localparam int QB = 34;
  localparam int QCNT_W = $clog2(QB);
  localparam int AW0 = NUM_W + DIV_SHIFT + 1;
  localparam int AW = ((AW0 > DET_W) ? AW0 : DET_W) + 1;
  localparam int BW = DET_W + 1;
  localparam int RW0 = BW + QB - 1;
  localparam int RW = (RW0 > AW) ? RW0 : AW;
  localparam int SAT_W = (SUMJ_W > DET_W + 1) ? SUMJ_W : DET_W + 1;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [31:0] word_t;

  localparam coef_t C_ONE = coef_t'(64'd1 << FRAC_BITS);
  localparam coef_t C_G = coef_t'(G_VAL);
  localparam logic signed [SAT_W-1:0] S_MAX = SAT_W'(64'h7FFF_FFFF);
  localparam logic signed [SAT_W-1:0] S_MIN = ~S_MAX;

  typedef struct packed {
    word_t [3:0] y;
    word_t [3:0] x;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  function automatic word_t sat32(input logic signed [SAT_W-1:0] v);
    word_t res;
    if (v > S_MAX) begin
      res = 32'sh7FFF_FFFF;
    end else if (v < S_MIN) begin
      res = 32'sh8000_0000;
    end else begin
      res = v[31:0];
    end
    return res;
  endfunction

  // c: xi derivative terms, d: eta derivative terms, both times four
  function automatic coef_t coef_c(input logic [1:0] p, input logic [1:0] k);
    coef_t b;
    coef_t res;
    b = p[0] ? C_G : -C_G;
    case (k)
      2'd0: res = b - C_ONE;
      2'd1: res = C_ONE - b;
      2'd2: res = C_ONE + b;
      default: res = -b - C_ONE;
    endcase
    return res;
  endfunction

  function automatic coef_t coef_d(input logic [1:0] p, input logic [1:0] k);
    coef_t a;
    coef_t res;
    a = p[1] ? C_G : -C_G;
    case (k)
      2'd0: res = a - C_ONE;
      2'd1: res = -a - C_ONE;
      2'd2: res = a + C_ONE;
      default: res = C_ONE - a;
    endcase
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- sv/qsd_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qsd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [255:0]  in_tdata,  // node0_x, node0_y, node1_x, ... node3_y
  input  wire logic          pop,
  output qsd_pkg::head_t     head
);
  import qsd_pkg::*;

  item_t      ent_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  item_t      in_item;
  logic       push;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      in_item.x[k] = in_tdata[64*k +: 32];
      in_item.y[k] = in_tdata[64*k+32 +: 32];
    end
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push = in_tvalid && in_tready;
  assign head.valid = (cnt_r != 2'd0);
  assign head.item = ent_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({push, pop})
        2'b10: cnt_r <= cnt_r + 2'd1;
        2'b01: cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- sv/qsd_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qsd_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic signed [qsd_pkg::NUM_W-1:0] num,
  input  wire logic signed [qsd_pkg::DET_W-1:0] den,
  output logic                               done,
  output qsd_pkg::word_t                     quot
);
  import qsd_pkg::*;

  logic [RW-1:0]     r_r;
  logic [RW-1:0]     ds_r;
  logic [QB-1:0]     q_r;
  logic [QCNT_W-1:0] cnt_r;
  logic              busy_r;
  logic              neg_r;
  logic              done_r;
  logic [NUM_W-1:0]  nmag;
  logic [DET_W-1:0]  dmag;
  logic [AW-1:0]     a_val;
  logic [BW-1:0]     b_val;
  logic              ge;
  logic [QB-2:0]     qmag;
  logic              ovf;

  assign nmag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  assign dmag = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
  // rounded quotient = floor((n * 2^(DIV_SHIFT+1) + d) / 2d)
  assign a_val = (AW'(nmag) << (DIV_SHIFT + 1)) + AW'(dmag);
  assign b_val = BW'(dmag) << 1;
  assign ge = (r_r >= ds_r);

  always_ff @(posedge clk) begin
    if (start) begin
      r_r <= RW'(a_val);
      ds_r <= RW'(b_val) << (QB - 1);
      q_r <= '0;
      neg_r <= num[NUM_W-1] ^ den[DET_W-1];
    end else if (busy_r) begin
      r_r <= ge ? r_r - ds_r : r_r;
      ds_r <= ds_r >> 1;
      q_r <= {q_r[QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= QCNT_W'(QB - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - QCNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign qmag = q_r[QB-2:0];
  assign ovf = q_r[QB-1];
  assign done = done_r;

  always_comb begin
    if (neg_r) begin
      if (ovf || qmag > (QB-1)'(64'h8000_0000)) begin
        quot = 32'sh8000_0000;
      end else begin
        quot = -qmag[31:0];
      end
    end else begin
      if (ovf || qmag > (QB-1)'(64'h7FFF_FFFF)) begin
        quot = 32'sh7FFF_FFFF;
      end else begin
        quot = qmag[31:0];
      end
    end
  end

endmodule
`default_nettype wire

// ----- sv/qsd_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module qsd_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire qsd_pkg::head_t head,
  output logic               pop,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [287:0]       out_tdata,  // dndx_n0..3, dndy_n0..3, jacobian_det
  output logic [2:0]         out_tuser,  // gauss_index, singular
  output logic               out_tlast   // last_point
);
  import qsd_pkg::*;

  `include "quad4_strain_displacement_unit_macros.svh"

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_PROD = 3'd1;
  localparam logic [2:0] ST_JAC  = 3'd2;
  localparam logic [2:0] ST_DETM = 3'd3;
  localparam logic [2:0] ST_DET  = 3'd4;
  localparam logic [2:0] ST_LOAD = 3'd5;
  localparam logic [2:0] ST_DIV  = 3'd6;
  localparam logic [2:0] ST_OUT  = 3'd7;

  localparam logic signed [SUMJ_W-1:0] J_HALF = SUMJ_W'(64'd1) << (FRAC_BITS + 1);
  localparam logic signed [SAT_W-1:0] D_HALF = SAT_W'(64'd1) << (FRAC_BITS - 1);

  logic [2:0] state_r, state_nxt;
  logic [1:0] pt_r;

  word_t xk [4];
  word_t yk [4];
  coef_t ck [4];
  coef_t dk [4];

  logic signed [PROD_W-1:0] pcx_r [4];
  logic signed [PROD_W-1:0] pcy_r [4];
  logic signed [PROD_W-1:0] pdx_r [4];
  logic signed [PROD_W-1:0] pdy_r [4];
  logic signed [SUMJ_W-1:0] s_cx, s_cy, s_dx, s_dy;
  word_t j11_r, j12_r, j21_r, j22_r;
  logic signed [63:0] m1_r, m2_r;
  logic signed [PROD_W-1:0] nx1_r [4];
  logic signed [PROD_W-1:0] nx2_r [4];
  logic signed [PROD_W-1:0] ny1_r [4];
  logic signed [PROD_W-1:0] ny2_r [4];
  logic signed [DET_W-1:0] det_r;
  logic signed [NUM_W-1:0] num_r [8];
  word_t quot [8];
  logic  [7:0] lane_done;
  logic  start;
  logic  sing;
  logic  can_load;
  word_t det_out;

  logic         out_valid_r;
  logic [287:0] out_data_r;
  logic [2:0]   out_user_r;
  logic         out_last_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      xk[k] = head.item.x[k];
      yk[k] = head.item.y[k];
      ck[k] = coef_c(pt_r, 2'(k));
      dk[k] = coef_d(pt_r, 2'(k));
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_PROD) begin
      for (int k = 0; k < 4; k++) begin
        pcx_r[k] <= xk[k] * ck[k];
        pcy_r[k] <= yk[k] * ck[k];
        pdx_r[k] <= xk[k] * dk[k];
        pdy_r[k] <= yk[k] * dk[k];
      end
    end
  end

  assign s_cx = SUMJ_W'(pcx_r[0]) + SUMJ_W'(pcx_r[1]) + SUMJ_W'(pcx_r[2]) + SUMJ_W'(pcx_r[3])
              + J_HALF;
  assign s_cy = SUMJ_W'(pcy_r[0]) + SUMJ_W'(pcy_r[1]) + SUMJ_W'(pcy_r[2]) + SUMJ_W'(pcy_r[3])
              + J_HALF;
  assign s_dx = SUMJ_W'(pdx_r[0]) + SUMJ_W'(pdx_r[1]) + SUMJ_W'(pdx_r[2]) + SUMJ_W'(pdx_r[3])
              + J_HALF;
  assign s_dy = SUMJ_W'(pdy_r[0]) + SUMJ_W'(pdy_r[1]) + SUMJ_W'(pdy_r[2]) + SUMJ_W'(pdy_r[3])
              + J_HALF;

  always_ff @(posedge clk) begin
    if (state_r == ST_JAC) begin
      j11_r <= sat32(SAT_W'(s_cx >>> (FRAC_BITS + 2)));
      j12_r <= sat32(SAT_W'(s_cy >>> (FRAC_BITS + 2)));
      j21_r <= sat32(SAT_W'(s_dx >>> (FRAC_BITS + 2)));
      j22_r <= sat32(SAT_W'(s_dy >>> (FRAC_BITS + 2)));
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DETM) begin
      m1_r <= j11_r * j22_r;
      m2_r <= j12_r * j21_r;
      for (int k = 0; k < 4; k++) begin
        nx1_r[k] <= j22_r * ck[k];
        nx2_r[k] <= j12_r * dk[k];
        ny1_r[k] <= j11_r * dk[k];
        ny2_r[k] <= j21_r * ck[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_DET) begin
      det_r <= DET_W'(m1_r) - DET_W'(m2_r);
      for (int k = 0; k < 4; k++) begin
        num_r[k] <= NUM_W'(nx1_r[k]) - NUM_W'(nx2_r[k]);
        num_r[k+4] <= NUM_W'(ny1_r[k]) - NUM_W'(ny2_r[k]);
      end
    end
  end

  assign start = (state_r == ST_LOAD);

  for (genvar i = 0; i < 8; i++) begin : g_lane
    qsd_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .start (start),
      .num   (num_r[i]),
      .den   (det_r),
      .done  (lane_done[i]),
      .quot  (quot[i])
    );
  end

  assign sing = (det_r == '0);
  assign det_out = sat32((SAT_W'(det_r) + D_HALF) >>> FRAC_BITS);
  assign can_load = (state_r == ST_OUT) && (!out_valid_r || out_tready);
  assign pop = can_load && (pt_r == 2'd3);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (head.valid) state_nxt = ST_PROD;
      ST_PROD: state_nxt = ST_JAC;
      ST_JAC:  state_nxt = ST_DETM;
      ST_DETM: state_nxt = ST_DET;
      ST_DET:  state_nxt = ST_LOAD;
      ST_LOAD: state_nxt = ST_DIV;
      ST_DIV:  if (&lane_done) state_nxt = ST_OUT;
      ST_OUT: begin
        if (can_load) begin
          state_nxt = (pt_r == 2'd3) ? ST_IDLE : ST_PROD;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pt_r <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE) begin
        pt_r <= 2'd0;
      end else if (can_load) begin
        pt_r <= pt_r + 2'd1;
      end
      if (can_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load) begin
      for (int k = 0; k < 8; k++) begin
        out_data_r[32*k +: 32] <= sing ? 32'd0 : quot[k];
      end
      out_data_r[287:256] <= det_out;
      out_user_r <= {sing, pt_r};
      out_last_r <= (pt_r == 2'd3);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
  assign out_tlast = out_last_r;

  `QSD_ASSERT(a_sing_zero, !(out_valid_r && out_user_r[2]) || (out_data_r[255:0] == '0))
  `QSD_ASSERT(a_sing_det, !(out_valid_r && out_user_r[2]) || (out_data_r[287:256] == '0))
  `QSD_ASSERT(a_last_pt, !out_valid_r || (out_last_r == (out_user_r[1:0] == 2'd3)))
  `QSD_IMPLY(a_pop_head, pop, head.valid)

endmodule
`default_nettype wire

// ----- sv/quad4_strain_displacement_unit.sv -----
// Quad4 strain-displacement unit.
// Input stream: one request per element, the four corner coordinates as signed
// fixed point (16 fraction bits), packed into in_tdata.
// Output stream: four results per element, one per 2x2 Gauss point in order
// (xi outer, eta inner): eight shape-function derivatives and the Jacobian
// determinant in out_tdata, Gauss index and singular flag in out_tuser, and
// out_tlast on the fourth point.
// A two-entry queue takes requests while earlier elements are still in work.
// Each Gauss point runs the product, Jacobian, determinant-multiply and
// determinant states, then eight parallel 34-step shift-subtract dividers,
// then loads the output register. The sequencer passes through an idle state
// between elements.
// When the receiver stalls, the finished result holds in the output register
// and the back end waits; the queue keeps taking requests until full.
// Synchronous active-low reset empties the queue, idles the sequencer and
// drops out_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module quad4_strain_displacement_unit (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [255:0]  in_tdata,  // node0_x, node0_y, node1_x, node1_y, ... node3_y
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic [287:0]       out_tdata, // dndx_n0..3, dndy_n0..3, jacobian_det
  output logic [2:0]         out_tuser, // gauss_index, singular
  output logic               out_tlast
);
  import qsd_pkg::*;

  head_t head;
  logic  pop;

  qsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .pop       (pop),
    .head      (head)
  );

  qsd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire

// ----- test/tb_quad4_strain_displacement_unit.sv -----
`timescale 1ns / 1ps
module tb_quad4_strain_displacement_unit;
  import qsd_pkg::*;

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [1:0] gauss_index;
    word_t      dndx [4];
    word_t      dndy [4];
    word_t      jacobian_det;
    logic       singular;
    logic       last_point;
  } gauss_result_t;

  class gauss_point_board;
    gauss_result_t expected_points[$];
    int            fails;

    function word_t clip32(wide_t v);
      if (v > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      if (v < -128'sh8000_0000) return 32'sh8000_0000;
      return v[31:0];
    endfunction

    function wide_t round_down_shift(wide_t v, int s);
      wide_t t;
      t = v + (128'sd1 <<< (s - 1));
      return t >>> s;
    endfunction

    function word_t scaled_quotient(wide_t n, wide_t den);
      logic neg;
      wide_t num, dv, q;
      neg = (n < 0) != (den < 0);
      num = (n < 0) ? -n : n;
      dv = (den < 0) ? -den : den;
      q = ((num <<< (FRAC_BITS - 1)) + dv) / (dv <<< 1);
      if (neg) begin
        if (q > 128'sh8000_0000) return 32'sh8000_0000;
        return word_t'(-q);
      end
      if (q > 128'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
      return word_t'(q);
    endfunction

    function void note_request(logic [255:0] nodes);
      wide_t one, g, a, b, sxx, sxy, sdx, sdy, j11, j12, j21, j22, det;
      wide_t x [4];
      wide_t y [4];
      wide_t c [4];
      wide_t d [4];
      gauss_result_t r;
      one = 128'sd1 <<< FRAC_BITS;
      g = (128'sd2479700525 + (128'sd1 <<< (31 - FRAC_BITS))) >>> (32 - FRAC_BITS);
      for (int k = 0; k < 4; k++) begin
        x[k] = word_t'(nodes[64*k +: 32]);
        y[k] = word_t'(nodes[64*k + 32 +: 32]);
      end
      for (int p = 0; p < 4; p++) begin
        a = p[1] ? g : -g;
        b = p[0] ? g : -g;
        c[0] = b - one; c[1] = one - b; c[2] = one + b; c[3] = -b - one;
        d[0] = a - one; d[1] = -a - one; d[2] = a + one; d[3] = one - a;
        sxx = 0; sxy = 0; sdx = 0; sdy = 0;
        for (int k = 0; k < 4; k++) begin
          sxx += c[k] * x[k];
          sxy += c[k] * y[k];
          sdx += d[k] * x[k];
          sdy += d[k] * y[k];
        end
        j11 = clip32(round_down_shift(sxx, FRAC_BITS + 2));
        j12 = clip32(round_down_shift(sxy, FRAC_BITS + 2));
        j21 = clip32(round_down_shift(sdx, FRAC_BITS + 2));
        j22 = clip32(round_down_shift(sdy, FRAC_BITS + 2));
        det = j11 * j22 - j12 * j21;
        r.gauss_index = p[1:0];
        r.singular = (det == 0);
        for (int k = 0; k < 4; k++) begin
          r.dndx[k] = r.singular ? 32'sd0 : scaled_quotient(j22 * c[k] - j12 * d[k], det);
          r.dndy[k] = r.singular ? 32'sd0 : scaled_quotient(j11 * d[k] - j21 * c[k], det);
        end
        r.jacobian_det = clip32(round_down_shift(det, FRAC_BITS));
        r.last_point = (p == 3);
        expected_points.push_back(r);
      end
    endfunction

    function void compare(string field, longint exp_v, longint act_v);
      if (exp_v != act_v) begin
        $error("%s expected %0d got %0d", field, exp_v, act_v);
        fails++;
      end
    endfunction

    function void check_result(logic [287:0] data, logic [2:0] user, logic last);
      gauss_result_t e;
      if (expected_points.size() == 0) begin
        $error("result with no request outstanding");
        fails++;
        return;
      end
      e = expected_points.pop_front();
      compare("gauss_index", e.gauss_index, user[1:0]);
      for (int k = 0; k < 4; k++) begin
        compare($sformatf("dndx_n%0d", k), e.dndx[k], word_t'(data[32*k +: 32]));
        compare($sformatf("dndy_n%0d", k), e.dndy[k], word_t'(data[128 + 32*k +: 32]));
      end
      compare("jacobian_det", e.jacobian_det, word_t'(data[256 +: 32]));
      compare("singular", e.singular, user[2]);
      compare("last_point", e.last_point, last);
    endfunction
  endclass

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0;
  logic         in_tready;
  logic [255:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 0;
  logic [287:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  gauss_point_board board = new();
  int burst_left = 0;
  int rx_cycle = 0;

  quad4_strain_displacement_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  // stall pattern: phases of full, random and sparse readiness, one long hold-off
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= 3000 && rx_cycle < 6000) begin
      out_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 700) % 3)
        0: out_tready <= 1'b1;
        1: out_tready <= $urandom_range(0, 1);
        default: out_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      board.check_result(out_tdata, out_tuser, out_tlast);
    end
  end

  task automatic send_element(logic [255:0] nodes);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 200);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    in_tvalid <= 1'b1;
    in_tdata <= nodes;
    do @(posedge clk); while (!in_tready);
    board.note_request(nodes);
    burst_left--;
  endtask

  function automatic logic [255:0] pack_nodes(word_t x [4], word_t y [4]);
    logic [255:0] v;
    for (int k = 0; k < 4; k++) begin
      v[64*k +: 32] = x[k];
      v[64*k + 32 +: 32] = y[k];
    end
    return v;
  endfunction

  task automatic send_square(int cx, int cy, int s, int jitter);
    word_t x [4];
    word_t y [4];
    int sx [4] = '{-1, 1, 1, -1};
    int sy [4] = '{-1, -1, 1, 1};
    for (int k = 0; k < 4; k++) begin
      x[k] = cx + sx[k] * s + int'($urandom_range(0, 2 * jitter)) - jitter;
      y[k] = cy + sy[k] * s + int'($urandom_range(0, 2 * jitter)) - jitter;
    end
    send_element(pack_nodes(x, y));
  endtask

  task automatic send_corners(word_t x0, word_t y0, word_t x1, word_t y1,
                              word_t x2, word_t y2, word_t x3, word_t y3);
    word_t x [4];
    word_t y [4];
    x = '{x0, x1, x2, x3};
    y = '{y0, y1, y2, y3};
    send_element(pack_nodes(x, y));
  endtask

  initial begin
    logic [255:0] raw;
    word_t px [4];
    word_t py [4];
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_corners(0, 0, 0, 0, 0, 0, 0, 0);
    send_corners(0, 0, 32'h10000, 0, 32'h10000, 32'h10000, 0, 32'h10000);
    send_corners(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_corners(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
    send_corners(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    send_corners(0, 0, 32'h10000, 32'h10000, 32'h20000, 32'h20000, 32'h30000, 32'h30000);
    send_corners(0, 0, 1, 0, 1, 1, 0, 1);
    send_corners(0, 0, 4, 0, 4, 4, 0, 4);
    send_corners(0, 0, 32'h200, 0, 32'h200, 32'h200, 0, 32'h200);
    send_corners(0, 0, 32'h7FFFFFFF, 0, 32'h7FFFFFFF, 1, 0, 1);
    send_corners(32'h40000000, 0, 32'hC0000000, 0, 32'hC0000000, 32'h40000000,
                 32'h40000000, 32'h40000000);
    send_corners(0, 0, 32'h20000, 0, 32'h20000, 32'h10000, 0, 32'h10000);
    send_corners(0, 0, 32'h10000, 0, 0, 0, 0, 32'h10000);
    send_corners(0, 0, 32'h20000, 0, 32'h30000, 32'h20000, 32'h10000, 32'h20000);
    send_corners(0, 0, 32'h10000, 0, 32'h8000, 32'h8000, 0, 32'h10000);

    for (int i = 0; i < 290; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: begin
          for (int b = 0; b < 8; b++) raw[32*b +: 32] = $urandom;
          send_element(raw);
        end
        3, 4: begin
          for (int k = 0; k < 4; k++) begin
            px[k] = $urandom_range(0, 3) * 32'h8000 + $urandom_range(0, 1);
            py[k] = px[k] * $urandom_range(0, 2);
          end
          send_element(pack_nodes(px, py));
        end
        5: send_square($urandom, $urandom, $urandom_range(1, 32'h3FFFFFFF), 0);
        default: send_square(int'($urandom_range(0, 32'h200000)) - 32'h100000,
                             int'($urandom_range(0, 32'h200000)) - 32'h100000,
                             1 << $urandom_range(0, 22), $urandom_range(0, 32'h4000));
      endcase
    end
    in_tvalid <= 1'b0;

    while (board.expected_points.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (board.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end
endmodule
